FILE: hw/rtl/sign_magnitude_fixed_point_alu_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sign-magnitude fixed-point ALU
// Concurrent checks clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SIGN_MAGNITUDE_FIXED_POINT_ALU_UNIT_ASSERT_SVH
`define SIGN_MAGNITUDE_FIXED_POINT_ALU_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// An implication property that must hold at every clock edge out of reset.
`define SMFX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// A condition that must never be true at a clock edge out of reset.
`define SMFX_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`else

`define SMFX_ASSERT(label, prop, msg)
`define SMFX_ASSERT_NEVER(label, cond, msg)

`endif

`endif

FILE: hw/rtl/smfx_pkg.sv
// ----------------------------------------------------------------------------
// smfx_pkg
// Types and constants shared by the sign-magnitude fixed-point ALU.
// ----------------------------------------------------------------------------
package smfx_pkg;

    localparam int WHOLE_W = 64;
    localparam int FRAC_W  = 64;
    localparam int MAG_W   = WHOLE_W + FRAC_W;
    localparam int OP_W    = 3;
    localparam int ORD_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_NEGATE = 3'd2,
        OP_HALVE  = 3'd3,
        OP_DOUBLE = 3'd4,
        OP_CMP    = 3'd5
    } t_op;

    localparam logic signed [ORD_W-1:0] ORD_LESS    = -2'sd1;
    localparam logic signed [ORD_W-1:0] ORD_EQUAL   = 2'sd0;
    localparam logic signed [ORD_W-1:0] ORD_GREATER = 2'sd1;

    typedef struct packed {
        logic               negative;
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
    } t_operand;

    typedef struct packed {
        logic                    negative;
        logic [WHOLE_W-1:0]      whole;
        logic [FRAC_W-1:0]       frac;
        logic                    overflow;
        logic                    underflow;
        logic signed [ORD_W-1:0] order;
    } t_result;

endpackage

FILE: hw/rtl/sign_magnitude_fixed_point_alu_unit.sv
// ----------------------------------------------------------------------------
// Sign-magnitude 64.64 fixed-point ALU
// Add, subtract, negate, halve, double and compare on sign-magnitude values.
// ----------------------------------------------------------------------------
// The unit accepts one operation per clock while the output is not stalled
// and returns one result beat per operation, in order, via the input and
// output registers. An input register feeds a single-pass 128-bit add,
// subtract and compare datapath whose result is captured in an output
// register. While the output is stalled the input register can still take one
// more operation if it is empty; once both registers are full, input ready
// drops until the result beat is taken.
// ----------------------------------------------------------------------------
module sign_magnitude_fixed_point_alu_unit
    import smfx_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata, low bit up: left_negative, left_whole, left_frac,
    // right_negative, right_whole, right_frac, zero padding
    input  logic [263:0] s_axis_tdata,
    // tuser, low bit up: operation
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata, low bit up: result_negative, result_whole, result_frac,
    // overflow_flag, underflow_flag, order, zero padding
    output logic [135:0] m_axis_tdata
);

    logic     r_in_valid;
    t_op      r_op;
    t_operand r_left;
    t_operand r_right;
    logic     r_out_valid;
    t_result  r_res;
    t_result  n_res;
    logic     out_ready;
    logic     res_mag_zero;
    logic     res_arith_clear;

    assign out_ready     = ~r_out_valid | m_axis_tready;
    assign s_axis_tready = ~r_in_valid | out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op             <= t_op'(s_axis_tuser);
            r_left.negative  <= s_axis_tdata[0];
            r_left.whole     <= s_axis_tdata[64:1];
            r_left.frac      <= s_axis_tdata[128:65];
            r_right.negative <= s_axis_tdata[129];
            r_right.whole    <= s_axis_tdata[193:130];
            r_right.frac     <= s_axis_tdata[257:194];
        end
        if (r_in_valid && out_ready) begin
            r_res <= n_res;
        end
    end

    smfx_alu u_alu (
        .i_op    (r_op),
        .i_left  ({r_left.negative, r_left.whole, r_left.frac}),
        .i_right ({r_right.negative, r_right.whole, r_right.frac}),
        .o_res   (n_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_res.order, r_res.underflow, r_res.overflow,
                            r_res.frac, r_res.whole, r_res.negative};

    assign res_mag_zero    = (r_res.whole == '0) && (r_res.frac == '0);
    assign res_arith_clear = res_mag_zero && !r_res.negative && !r_res.overflow
                             && !r_res.underflow;

`include "sign_magnitude_fixed_point_alu_unit_assert.svh"

    `SMFX_ASSERT(a_zero_is_positive, (r_out_valid && res_mag_zero) |-> !r_res.negative, "negative zero")
    `SMFX_ASSERT(a_order_alone, (r_out_valid && r_res.order != ORD_EQUAL) |-> res_arith_clear, "order mixed")
    `SMFX_ASSERT_NEVER(a_flags_exclusive, r_out_valid && r_res.overflow && r_res.underflow, "both flags")

endmodule

FILE: hw/rtl/smfx_alu.sv
// ----------------------------------------------------------------------------
// smfx_alu
// Single-pass datapath: 128-bit magnitude add, subtract, shift and compare.
// ----------------------------------------------------------------------------
module smfx_alu
    import smfx_pkg::*;
(
    input  t_op      i_op,
    input  t_operand i_left,
    input  t_operand i_right,
    output t_result  o_res
);

    logic [MAG_W-1:0] l_mag;
    logic [MAG_W-1:0] r_mag_in;
    logic             l_zero;
    logic             r_zero;
    logic             l_neg;
    logic             r_neg;
    logic             r_neg_eff;
    logic [MAG_W:0]   sum;
    logic [MAG_W:0]   diff_lr;
    logic [MAG_W-1:0] diff_rl;
    logic             l_lt_r;
    logic             l_eq_r;
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             ovf;
    logic             unf;
    logic signed [ORD_W-1:0] ord;

    assign l_mag    = {i_left.whole, i_left.frac};
    assign r_mag_in = {i_right.whole, i_right.frac};
    assign l_zero   = (l_mag == '0);
    assign r_zero   = (r_mag_in == '0);

    // A zero magnitude counts as positive whatever its sign bit says.
    assign l_neg = i_left.negative & ~l_zero;
    assign r_neg = i_right.negative & ~r_zero;
    assign r_neg_eff = (i_op == OP_SUB) ? (~r_neg & ~r_zero) : r_neg;

    assign sum     = {1'b0, l_mag} + {1'b0, r_mag_in};
    assign diff_lr = {1'b0, l_mag} - {1'b0, r_mag_in};
    assign diff_rl = r_mag_in - l_mag;
    assign l_lt_r  = diff_lr[MAG_W];
    assign l_eq_r  = (l_mag == r_mag_in);

    always_comb begin
        mag = '0;
        neg = 1'b0;
        ovf = 1'b0;
        unf = 1'b0;
        ord = ORD_EQUAL;
        unique case (i_op)
            OP_ADD, OP_SUB: begin
                if (l_neg == r_neg_eff) begin
                    mag = sum[MAG_W-1:0];
                    ovf = sum[MAG_W];
                    neg = l_neg;
                end else if (!l_lt_r) begin
                    mag = diff_lr[MAG_W-1:0];
                    neg = l_neg;
                end else begin
                    mag = diff_rl;
                    neg = r_neg_eff;
                end
            end
            OP_NEGATE: begin
                mag = l_mag;
                neg = ~l_zero & ~l_neg;
            end
            OP_HALVE: begin
                unf = l_mag[0];
                mag = {1'b0, l_mag[MAG_W-1:1]};
                neg = l_neg;
            end
            OP_DOUBLE: begin
                ovf = l_mag[MAG_W-1];
                mag = {l_mag[MAG_W-2:0], 1'b0};
                neg = l_neg;
            end
            OP_CMP: begin
                if (l_neg != r_neg) begin
                    ord = l_neg ? ORD_LESS : ORD_GREATER;
                end else if (l_eq_r) begin
                    ord = ORD_EQUAL;
                end else begin
                    // Both negative flips the magnitude ordering.
                    ord = (~l_lt_r ^ l_neg) ? ORD_GREATER : ORD_LESS;
                end
            end
            default: begin
                mag = '0;
            end
        endcase
    end

    assign o_res.negative  = neg & (mag != '0);
    assign o_res.whole     = mag[MAG_W-1:FRAC_W];
    assign o_res.frac      = mag[FRAC_W-1:0];
    assign o_res.overflow  = ovf;
    assign o_res.underflow = unf;
    assign o_res.order     = ord;

endmodule
